FILE: rtl/bvrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvrl_pkg
// Shared types, register defaults and fixed-point helpers for the base
// velocity ramp limiter.
// ----------------------------------------------------------------------------
package bvrl_pkg;

  // Field widths.
  localparam int unsigned VelW  = 16;
  localparam int unsigned RegW  = 15;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned ModeW = 2;
  localparam int unsigned AxisShift = 14;

  // Wide enough for a 16-bit value plus or minus a 15-bit margin.
  localparam int unsigned SumW = VelW + 2;

  // Register reset values.
  localparam logic [RegW-1:0] MaxFwdVelRst    = 15'd4096;
  localparam logic [RegW-1:0] MaxRevVelRst    = 15'd2048;
  localparam logic [RegW-1:0] MaxTurnVelRst   = 15'd12288;
  localparam logic [RegW-1:0] AccelStepLinRst = 15'd137;
  localparam logic [RegW-1:0] AccelStepAngRst = 15'd410;
  localparam logic [RegW-1:0] WindupLinRst    = 15'd1024;
  localparam logic [RegW-1:0] WindupAngRst    = 15'd3072;

  // Request kinds.
  typedef enum logic [ModeW-1:0] {
    MODE_JOY  = 2'd0,
    MODE_ODO  = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [IdxW-1:0] {
    REG_MAX_FWD_VEL    = 3'd0,
    REG_MAX_REV_VEL    = 3'd1,
    REG_MAX_TURN_VEL   = 3'd2,
    REG_ACCEL_STEP_LIN = 3'd3,
    REG_ACCEL_STEP_ANG = 3'd4,
    REG_WINDUP_LIN     = 3'd5,
    REG_WINDUP_ANG     = 3'd6
  } reg_idx_t;

  typedef logic signed [VelW-1:0] vel_t;
  typedef logic signed [SumW-1:0] sum_t;

  // Axis (Q1.14) times gain (Q3.12), floor shift by 14, saturate to 16 bits.
  function automatic vel_t scale_axis(input vel_t axis, input logic [RegW-1:0] gain);
    logic signed [31:0] prod;
    logic signed [31:0] q;
    begin
      prod = 32'(axis) * $signed({17'd0, gain});
      q = prod >>> AxisShift;
      if (q > 32'sd32767) begin
        scale_axis = 16'sh7fff;
      end else if (q < -32'sd32768) begin
        scale_axis = 16'sh8000;
      end else begin
        scale_axis = q[VelW-1:0];
      end
    end
  endfunction

  // Keep the command within a margin of the measured value, on the side of
  // its own sign. The result always fits 16 bits.
  function automatic vel_t windup_clamp(input vel_t ramp, input vel_t odo,
                                        input logic [RegW-1:0] w);
    sum_t lim;
    sum_t r;
    begin
      r = SumW'(ramp);
      if (!ramp[VelW-1]) begin
        lim = SumW'(odo) + $signed({3'd0, w});
        windup_clamp = (r < lim) ? ramp : lim[VelW-1:0];
      end else begin
        lim = SumW'(odo) - $signed({3'd0, w});
        windup_clamp = (r > lim) ? ramp : lim[VelW-1:0];
      end
    end
  endfunction

  // Move toward the target by at most one step.
  function automatic vel_t slew(input vel_t target, input vel_t ramp,
                                input logic [RegW-1:0] step);
    sum_t lim;
    sum_t t;
    begin
      t = SumW'(target);
      if (target > ramp) begin
        lim = SumW'(ramp) + $signed({3'd0, step});
        slew = (t < lim) ? target : lim[VelW-1:0];
      end else begin
        lim = SumW'(ramp) - $signed({3'd0, step});
        slew = (t > lim) ? target : lim[VelW-1:0];
      end
    end
  endfunction

endpackage

FILE: rtl/base_velocity_ramp_limiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_velocity_ramp_limiter_core
// Two-axis slew-rate limiter with windup clamp for mobile base commands.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its input is not
// stalled, and returns its result, if it has one, from a result register:
// the request is captured in an input register, and a single pass of logic
// (the target multiply for joystick requests, or the windup clamp followed
// by the slew for ticks) loads the result register. Throughput is set only
// by the result register: while a result is stalled, one more request is
// held in the input register and the input stalls after that. A joystick
// request with the deadman released returns a zero stop command; ticks
// while active return the ramped command; all other requests return nothing.
module base_velocity_ramp_limiter_core
  import bvrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ModeW-1:0]       mode,
  input  logic                   deadman,
  input  logic signed [VelW-1:0] axis_lin,
  input  logic signed [VelW-1:0] axis_ang,
  input  logic signed [VelW-1:0] meas_lin,
  input  logic signed [VelW-1:0] meas_ang,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [VelW-1:0] cmd_lin,
  output logic signed [VelW-1:0] cmd_ang,
  output logic                   is_stop,
  // Configuration
  input  logic                   cfg_write,
  input  logic [IdxW-1:0]        cfg_index,
  input  logic [RegW-1:0]        cfg_data
);

  // Configuration registers.
  logic [RegW-1:0] max_fwd_vel, max_rev_vel, max_turn_vel;
  logic [RegW-1:0] accel_step_lin, accel_step_ang;
  logic [RegW-1:0] windup_lin, windup_ang;

  // Input register.
  logic                   item_valid;
  logic [ModeW-1:0]       item_mode;
  logic                   item_deadman;
  vel_t                   item_axis_lin, item_axis_ang;
  vel_t                   item_meas_lin, item_meas_ang;

  // Block state.
  logic active;
  vel_t target_lin, target_ang;
  vel_t ramp_lin, ramp_ang;
  vel_t odo_lin, odo_ang;

  logic advance;
  logic in_accept;

  // Combinational results of the single pass.
  logic active_next;
  vel_t target_lin_next, target_ang_next;
  vel_t ramp_lin_next, ramp_ang_next;
  vel_t odo_lin_next, odo_ang_next;
  vel_t clamp_lin, clamp_ang;
  logic emit, emit_stop;

  // The held request moves on whenever the result register is free or
  // being emptied this cycle.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fwd_vel    <= MaxFwdVelRst;
      max_rev_vel    <= MaxRevVelRst;
      max_turn_vel   <= MaxTurnVelRst;
      accel_step_lin <= AccelStepLinRst;
      accel_step_ang <= AccelStepAngRst;
      windup_lin     <= WindupLinRst;
      windup_ang     <= WindupAngRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_FWD_VEL:    max_fwd_vel    <= cfg_data;
        REG_MAX_REV_VEL:    max_rev_vel    <= cfg_data;
        REG_MAX_TURN_VEL:   max_turn_vel   <= cfg_data;
        REG_ACCEL_STEP_LIN: accel_step_lin <= cfg_data;
        REG_ACCEL_STEP_ANG: accel_step_ang <= cfg_data;
        REG_WINDUP_LIN:     windup_lin     <= cfg_data;
        REG_WINDUP_ANG:     windup_ang     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_mode     <= mode;
      item_deadman  <= deadman;
      item_axis_lin <= axis_lin;
      item_axis_ang <= axis_ang;
      item_meas_lin <= meas_lin;
      item_meas_ang <= meas_ang;
    end
  end

  // Windup clamp ahead of the slew for ticks.
  assign clamp_lin = windup_clamp(ramp_lin, odo_lin, windup_lin);
  assign clamp_ang = windup_clamp(ramp_ang, odo_ang, windup_ang);

  // Next state and result for the held request.
  always_comb begin
    active_next     = active;
    target_lin_next = target_lin;
    target_ang_next = target_ang;
    ramp_lin_next   = ramp_lin;
    ramp_ang_next   = ramp_ang;
    odo_lin_next    = odo_lin;
    odo_ang_next    = odo_ang;
    emit            = 1'b0;
    emit_stop       = 1'b0;
    unique case (item_mode)
      MODE_JOY: begin
        if (!item_deadman) begin
          active_next     = 1'b0;
          target_lin_next = '0;
          target_ang_next = '0;
          ramp_lin_next   = '0;
          ramp_ang_next   = '0;
          emit            = 1'b1;
          emit_stop       = 1'b1;
        end else begin
          active_next     = 1'b1;
          target_lin_next = scale_axis(item_axis_lin,
                                       (item_axis_lin > 16'sd0) ? max_fwd_vel : max_rev_vel);
          target_ang_next = scale_axis(item_axis_ang, max_turn_vel);
        end
      end
      MODE_ODO: begin
        odo_lin_next = item_meas_lin;
        odo_ang_next = item_meas_ang;
      end
      MODE_TICK: begin
        if (active) begin
          ramp_lin_next = slew(target_lin, clamp_lin, accel_step_lin);
          ramp_ang_next = slew(target_ang, clamp_ang, accel_step_ang);
          emit          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      target_lin <= '0;
      target_ang <= '0;
      ramp_lin   <= '0;
      ramp_ang   <= '0;
      odo_lin    <= '0;
      odo_ang    <= '0;
    end else if (item_valid && advance) begin
      active     <= active_next;
      target_lin <= target_lin_next;
      target_ang <= target_ang_next;
      ramp_lin   <= ramp_lin_next;
      ramp_ang   <= ramp_ang_next;
      odo_lin    <= odo_lin_next;
      odo_ang    <= odo_ang_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && emit) begin
      cmd_lin <= ramp_lin_next;
      cmd_ang <= ramp_ang_next;
      is_stop <= emit_stop;
    end
  end

`ifndef SYNTHESIS
  // A stop command always carries zero velocities.
  a_stop_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_stop |-> cmd_lin == 16'sd0 && cmd_ang == 16'sd0)
    else $error("stop command with nonzero velocity");

  // After a deadman release the block is inactive with cleared ramps and a stop command out.
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    item_valid && advance && item_mode == MODE_JOY && !item_deadman
    |=> !active && ramp_lin == 16'sd0 && ramp_ang == 16'sd0 && out_valid && is_stop)
    else $error("deadman release did not clear state");

  // The input stalls only while a request is held behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without cause");
`endif

endmodule
